### rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants of the keyed count table: field widths, table
// size, request kinds, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam int KIND_W    = 2;
    localparam int CODE_W    = 32;
    localparam int QTY_W     = 16;
    localparam int PRICE_W   = 24;
    localparam int PROD_W    = PRICE_W + QTY_W;
    localparam int SUM_W     = 47;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_TAKE   = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic search;
        logic read;
        logic update;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
    } t_status;

endpackage

### rtl/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// Controller of the keyed count table: steps one transaction through search,
// store read, update and finish; a clear skips store read and update.
// ----------------------------------------------------------------------------
module kct_ctrl
    import kct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // A clear needs no lookup and goes straight to the finish step.
                if (i_status.is_clear) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.search = 1'b1;
                    n_state      = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/kct_datapath.sv
// ----------------------------------------------------------------------------
// kct_datapath
// Datapath of the keyed count table: key compare array with occupancy bits,
// price and quantity memories, quantity update, multiplier and running total.
// ----------------------------------------------------------------------------
module kct_datapath
    import kct_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  logic [KIND_W-1:0]           i_kind,
    input  logic signed [CODE_W-1:0]    i_item_code,
    input  logic [QTY_W-1:0]            i_amount,
    input  logic [PRICE_W-1:0]          i_unit_price,
    output logic                        o_done,
    output logic                        o_found,
    output logic                        o_dropped,
    output logic signed [CODE_W-1:0]    o_code_out,
    output logic [PRICE_W-1:0]          o_price_out,
    output logic [QTY_W-1:0]            o_quantity_out,
    output logic [SUM_W-1:0]            o_total_value,
    output logic [OUT_CNT_W-1:0]        o_entry_count
);

    // Captured request.
    t_kind               r_kind;
    logic [CODE_W-1:0]   r_code;
    logic [QTY_W-1:0]    r_amount;
    logic [PRICE_W-1:0]  r_price;

    // Key array and occupancy; every key has its own comparator.
    logic [ENTRIES-1:0]  r_occ;
    logic [CODE_W-1:0]   r_keys [ENTRIES];
    logic [CNT_W-1:0]    r_used;
    logic [SUM_W-1:0]    r_sum;

    // Stores read at the matched entry.
    logic [PRICE_W-1:0]  price_mem [ENTRIES];
    logic [QTY_W-1:0]    qty_mem   [ENTRIES];
    logic [PRICE_W-1:0]  r_rd_price;
    logic [QTY_W-1:0]    r_rd_qty;

    // Search results.
    logic                r_hit;
    logic                r_full;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [IDX_W-1:0]    r_free_idx;

    // Update results.
    logic [PROD_W-1:0]   r_prod;
    logic                r_sub;
    logic                r_found;
    logic                r_dropped;
    logic [PRICE_W-1:0]  r_out_price;
    logic [QTY_W-1:0]    r_out_qty;

    logic                done_hit;
    logic [IDX_W-1:0]    done_hit_idx;
    logic [IDX_W-1:0]    done_free_idx;

    logic [QTY_W:0]      qty_sum;
    logic [QTY_W-1:0]    n_qty;
    logic [PRICE_W-1:0]  mul_a;
    logic [QTY_W-1:0]    mul_b;
    logic                n_sub;
    logic                n_found;
    logic                n_dropped;
    logic [PRICE_W-1:0]  n_out_price;
    logic [QTY_W-1:0]    n_out_qty;
    logic                wr_qty;
    logic                do_insert;
    logic                do_free;
    logic [IDX_W-1:0]    wr_idx;

    assign o_status.is_clear = (r_kind == KIND_CLEAR);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= t_kind'(i_kind);
            r_code   <= i_item_code;
            r_amount <= i_amount;
            r_price  <= i_unit_price;
        end
    end

    // Lowest matching entry and lowest free entry.
    always_comb begin
        done_hit      = 1'b0;
        done_hit_idx  = '0;
        done_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_occ[i] && (r_keys[i] == r_code)) begin
                done_hit     = 1'b1;
                done_hit_idx = IDX_W'(i);
            end
            if (!r_occ[i]) begin
                done_free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_hit      <= done_hit;
            r_hit_idx  <= done_hit_idx;
            r_free_idx <= done_free_idx;
            r_full     <= &r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_price <= price_mem[r_hit_idx];
            r_rd_qty   <= qty_mem[r_hit_idx];
        end
    end

    // New quantity, total adjustment operands and the result fields.
    always_comb begin
        qty_sum     = {1'b0, r_rd_qty} + {1'b0, r_amount};
        n_qty       = r_rd_qty;
        mul_a       = r_rd_price;
        mul_b       = '0;
        n_sub       = 1'b0;
        n_found     = r_hit;
        n_dropped   = 1'b0;
        n_out_price = '0;
        n_out_qty   = '0;
        wr_qty      = 1'b0;
        do_insert   = 1'b0;
        do_free     = 1'b0;
        wr_idx      = r_hit ? r_hit_idx : r_free_idx;
        if (r_hit) begin
            n_out_price = r_rd_price;
            case (r_kind)
                KIND_ADD: begin
                    n_qty  = qty_sum[QTY_W] ? {QTY_W{1'b1}} : qty_sum[QTY_W-1:0];
                    // A saturated add raises the quantity by the headroom that was left.
                    mul_b  = qty_sum[QTY_W] ? ~r_rd_qty : r_amount;
                    wr_qty = 1'b1;
                end
                KIND_TAKE: begin
                    n_sub = 1'b1;
                    if (r_rd_qty > QTY_W'(1)) begin
                        n_qty  = r_rd_qty - QTY_W'(1);
                        mul_b  = QTY_W'(1);
                        wr_qty = 1'b1;
                    end else begin
                        n_qty   = '0;
                        mul_b   = r_rd_qty;
                        do_free = 1'b1;
                    end
                end
                default: begin
                    n_qty = r_rd_qty;
                end
            endcase
            n_out_qty = n_qty;
        end else if (r_kind == KIND_ADD) begin
            if (r_full) begin
                n_dropped = 1'b1;
            end else begin
                do_insert   = 1'b1;
                wr_qty      = 1'b1;
                n_qty       = r_amount;
                mul_a       = r_price;
                mul_b       = r_amount;
                n_out_price = r_price;
                n_out_qty   = r_amount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_prod      <= PROD_W'(mul_a) * PROD_W'(mul_b);
            r_sub       <= n_sub;
            r_found     <= n_found;
            r_dropped   <= n_dropped;
            r_out_price <= n_out_price;
            r_out_qty   <= n_out_qty;
            if (wr_qty) begin
                qty_mem[wr_idx] <= n_qty;
            end
            if (do_insert) begin
                price_mem[wr_idx] <= r_price;
                r_keys[wr_idx]    <= r_code;
            end
        end
    end

    // Occupancy, entry count and running total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_used <= '0;
            r_sum  <= '0;
        end else if (i_cmd.finish && (r_kind == KIND_CLEAR)) begin
            r_occ  <= '0;
            r_used <= '0;
            r_sum  <= '0;
        end else if (i_cmd.update) begin
            if (do_insert) begin
                r_occ[wr_idx] <= 1'b1;
                r_used        <= r_used + CNT_W'(1);
            end else if (do_free) begin
                r_occ[wr_idx] <= 1'b0;
                r_used        <= r_used - CNT_W'(1);
            end
        end else if (i_cmd.finish) begin
            r_sum <= r_sub ? (r_sum - SUM_W'(r_prod)) : (r_sum + SUM_W'(r_prod));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_code_out <= r_code;
            if (r_kind == KIND_CLEAR) begin
                o_found        <= 1'b0;
                o_dropped      <= 1'b0;
                o_price_out    <= '0;
                o_quantity_out <= '0;
            end else begin
                o_found        <= r_found;
                o_dropped      <= r_dropped;
                o_price_out    <= r_out_price;
                o_quantity_out <= r_out_qty;
            end
        end
    end

    // Total and count follow the state right after the finish edge.
    assign o_total_value = r_sum;
    assign o_entry_count = OUT_CNT_W'(r_used);

endmodule

### rtl/keyed_count_table_core.sv
// ----------------------------------------------------------------------------
// keyed_count_table_core
// Keyed count table: a table of coded entries with price and quantity that
// handles add, take-one, lookup and clear transactions, and reports the
// running inventory value and the number of occupied entries.
// ----------------------------------------------------------------------------
// Sequence: the accepting edge captures the request; the controller then
// steps through search, store read, update (multiply) and finish (total),
// and o_done is registered from finish; a clear goes from search straight to
// finish. busy is high in every step after idle; start is taken only in idle.
// Reset: synchronous, active low; it empties the table and zeroes the total.
// The result is shown for one cycle on o_done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module keyed_count_table_core
    import kct_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [KIND_W-1:0]           i_kind,
    input  logic signed [CODE_W-1:0]    i_item_code,
    input  logic [QTY_W-1:0]            i_amount,
    input  logic [PRICE_W-1:0]          i_unit_price,
    output logic                        o_done,
    output logic                        o_found,
    output logic                        o_dropped,
    output logic signed [CODE_W-1:0]    o_code_out,
    output logic [PRICE_W-1:0]          o_price_out,
    output logic [QTY_W-1:0]            o_quantity_out,
    output logic [SUM_W-1:0]            o_total_value,
    output logic [OUT_CNT_W-1:0]        o_entry_count
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences each transaction; it never looks at payload
    // data other than the single status flag that marks a clear.
    kct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // The datapath holds the key compare array, the price and quantity
    // memories, the multiplier that forms price times quantity change, and
    // the running total and entry count.
    kct_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_kind         (i_kind),
        .i_item_code    (i_item_code),
        .i_amount       (i_amount),
        .i_unit_price   (i_unit_price),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_dropped      (o_dropped),
        .o_code_out     (o_code_out),
        .o_price_out    (o_price_out),
        .o_quantity_out (o_quantity_out),
        .o_total_value  (o_total_value),
        .o_entry_count  (o_entry_count)
    );

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    // A result appears only once the sequence has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a transaction");

    // A refused insert means the code was not found and the table is full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dropped) |-> (!o_found && (o_entry_count == OUT_CNT_W'(ENTRIES))))
        else $error("insert dropped while table not full");

    // A refused insert reports neither a price nor a quantity.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dropped) |-> ((o_price_out == '0) && (o_quantity_out == '0)))
        else $error("dropped insert reports entry data");

endmodule
